// ===== src/pulse_train_heating_sum_top_defines.svh =====
// Assertion macros shared by the pulse-train heating sum RTL.
`ifndef PULSE_TRAIN_HEATING_SUM_TOP_DEFINES_SVH
`define PULSE_TRAIN_HEATING_SUM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PTHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pths assertion failed");
`define PTHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pths assertion failed");
`else
`define PTHS_ASSERT_NOW(lbl, ante, cons)
`define PTHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/pths_pkg.sv =====
// Shared types, constants and the gaussian table generator of the heating sum block.
`default_nettype none
package pths_pkg;

  localparam int MAX_EVENTS_DEF  = 64;
  localparam int GAUSS_DEPTH_DEF = 256;

  localparam logic [1:0] MODE_TRI    = 2'd0;
  localparam logic [1:0] MODE_SQUARE = 2'd1;
  localparam logic [1:0] MODE_GAUSS  = 2'd2;

  localparam logic [1:0] CFG_SHAPE  = 2'd0;
  localparam logic [1:0] CFG_BG     = 2'd1;
  localparam logic [1:0] CFG_INV    = 2'd2;
  localparam logic [1:0] CFG_ACTIVE = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_AMP   = 2'd1,
    ACC_QUOT  = 2'd2,
    ACC_GAUSS = 2'd3
  } pths_acc_e;

  typedef struct packed {
    logic      load;
    logic      init;
    logic      fetch;
    logic      check;
    logic      tmul;
    logic      div_load;
    logic      div_step;
    logic      gsq;
    logic      ghi;
    logic      glo;
    logic      gidx;
    logic      grom;
    pths_acc_e acc_sel;
    logic      next;
    logic      out_load;
  } pths_cmd_t;

  typedef struct packed {
    logic       last;
    logic       in_range;
    logic       zero_width;
    logic       div_done;
    logic       out_busy;
    logic [1:0] mode;
  } pths_status_t;

  // Q1.31 Taylor series of exp(-y), raised to the 64th power by six squarings.
  function automatic logic [15:0] gauss_entry(input longint unsigned y);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint unsigned e;
    term = 64'd1 << 31;
    sum  = 64'd1 << 31;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * y) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = sum;
    for (int i = 0; i < 6; i++) begin
      v = (v * v) >> 31;
    end
    e = (v * 64'd65536 + (64'd1 << 30)) >> 31;
    if (e > 64'd65535) begin
      e = 64'd65535;
    end
    return e[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/pulse_train_heating_sum_top.sv =====
// Pulse-train heating sum top level: a load transfer is accepted while idle and the block is
// ready again next cycle. An evaluation walks the active events one at a time: an event out of
// its interval, a square pulse or a zero-length triangle needs only fetch and check, a gaussian
// adds product, index and table states, a triangle a restoring divider that sets the pace. The
// result register is loaded once the last result is taken, then frees the input side; reset
// clears control and configuration; the event memory holds no defined contents until loaded.
`default_nettype none
`include "pulse_train_heating_sum_top_defines.svh"
module pulse_train_heating_sum_top import pths_pkg::*; #(
  parameter int MaxEvents       = MAX_EVENTS_DEF,
  parameter int GaussTableDepth = GAUSS_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [5:0]  event_index_i,
  input  wire logic [31:0] event_start_i,
  input  wire logic [31:0] event_end_i,
  input  wire logic [23:0] event_amp_i,
  input  wire logic [31:0] time_now_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      heat_o,
  output logic             saturated_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  pths_cmd_t    cmd;
  pths_status_t status;

  assign cfg_ready_o = 1'b1;

  pths_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pths_datapath #(
    .MaxEvents       (MaxEvents),
    .GaussTableDepth (GaussTableDepth)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .event_index_i (event_index_i),
    .event_start_i (event_start_i),
    .event_end_i   (event_end_i),
    .event_amp_i   (event_amp_i),
    .time_now_i    (time_now_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .heat_o        (heat_o),
    .saturated_o   (saturated_o)
  );

  `PTHS_ASSERT_NEXT(a_eval_busy, in_valid_i && in_ready_o && command_i == CMD_EVAL, !in_ready_o)
  `PTHS_ASSERT_NEXT(a_load_quick, in_valid_i && in_ready_o && command_i == CMD_LOAD, in_ready_o)
  `PTHS_ASSERT_NOW(a_sat_max, out_valid_o && saturated_o, heat_o == 32'hFFFF_FFFF)

endmodule
`default_nettype wire

// ===== src/pths_datapath.sv =====
// Datapath of the heating sum: event memory, configuration, divider, gaussian path and sum.
`default_nettype none
module pths_datapath import pths_pkg::*; #(
  parameter int MaxEvents       = MAX_EVENTS_DEF,
  parameter int GaussTableDepth = GAUSS_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pths_cmd_t    cmd_i,
  output pths_status_t      status_o,
  input  wire logic         cfg_valid_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic [5:0]   event_index_i,
  input  wire logic [31:0]  event_start_i,
  input  wire logic [31:0]  event_end_i,
  input  wire logic [23:0]  event_amp_i,
  input  wire logic [31:0]  time_now_i,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic [31:0]       heat_o,
  output logic              saturated_o
);

  localparam int AW = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;
  localparam int CW = $clog2(MaxEvents + 1);
  localparam int IW = $clog2(GaussTableDepth);
  localparam int SW = 38 + IW + 1;

  logic [1:0]  shape_q;
  logic [31:0] bg_q;
  logic [31:0] inv_q;
  logic [6:0]  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= MODE_TRI;
      bg_q     <= '0;
      inv_q    <= '0;
      active_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHAPE:  shape_q  <= cfg_data_i[1:0];
        CFG_BG:     bg_q     <= cfg_data_i;
        CFG_INV:    inv_q    <= cfg_data_i;
        CFG_ACTIVE: active_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [87:0]   mem [MaxEvents];
  logic [87:0]   rd_q;
  logic [AW+5:0] widx_ext;
  logic [AW-1:0] widx;
  logic          idx_ok;
  logic [CW-1:0] i_q;
  logic [CW-1:0] lim_q;

  assign widx_ext = (AW + 6)'(event_index_i);
  assign widx     = widx_ext[AW-1:0];
  assign idx_ok   = 32'(event_index_i) < 32'(MaxEvents);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && idx_ok) begin
      mem[widx] <= {event_start_i, event_end_i, event_amp_i};
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[i_q[AW-1:0]];
    end
  end

  logic [31:0] s_w, e_w, t_q;
  logic [23:0] a_w;
  logic [32:0] twice_t, sum_se, mdiff;
  logic        lower;
  logic [31:0] width_w, diff_w;

  assign s_w     = rd_q[87:56];
  assign e_w     = rd_q[55:24];
  assign a_w     = rd_q[23:0];
  assign twice_t = {t_q, 1'b0};
  assign sum_se  = {1'b0, s_w} + {1'b0, e_w};
  assign lower   = twice_t < sum_se;
  assign width_w = e_w - s_w;
  assign diff_w  = lower ? (t_q - s_w) : (e_w - t_q);
  assign mdiff   = lower ? (sum_se - twice_t) : (twice_t - sum_se);

  logic [31:0] width_q, diff_q, m_q, rem_q;
  logic [56:0] num_q;
  logic [24:0] qsh_q;
  logic [4:0]  dcnt_q;
  logic [63:0] sq_q, phi_q, plo_q;
  logic [IW-1:0] idx_q;
  logic [15:0] romv_q;
  logic [32:0] r2;
  logic        ge;
  logic [64:0] hi_sum;
  logic [37:0] full;
  logic [SW-1:0] scaled;
  logic [IW-1:0] idx_d;

  assign r2     = {rem_q, qsh_q[24]};
  assign ge     = r2 >= {1'b0, width_q};
  assign hi_sum = {1'b0, phi_q} + 65'(plo_q[63:32]);
  assign full   = {hi_sum[5:0], plo_q[31:0]};
  assign scaled = SW'(full) * SW'(GaussTableDepth);
  assign idx_d  = (hi_sum >= 65'd64) ? IW'(GaussTableDepth - 1) : scaled[38 +: IW];

  logic [15:0] rom [GaussTableDepth];
  for (genvar k = 0; k < GaussTableDepth; k++) begin : g_rom
    localparam longint unsigned Y = (64'(k) << 31) / (4 * GaussTableDepth);
    assign rom[k] = gauss_entry(Y);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      width_q <= width_w;
      diff_q  <= diff_w;
      m_q     <= mdiff[31:0];
    end
    if (cmd_i.tmul) begin
      num_q <= 57'({a_w, 1'b0}) * 57'(diff_q);
    end
    if (cmd_i.div_load) begin
      rem_q  <= num_q[56:25];
      qsh_q  <= num_q[24:0];
      dcnt_q <= 5'd25;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? 32'(r2 - {1'b0, width_q}) : r2[31:0];
      qsh_q  <= {qsh_q[23:0], ge};
      dcnt_q <= dcnt_q - 5'd1;
    end
    if (cmd_i.gsq) begin
      sq_q <= 64'(m_q) * 64'(m_q);
    end
    if (cmd_i.ghi) begin
      phi_q <= 64'(sq_q[63:32]) * 64'(inv_q);
    end
    if (cmd_i.glo) begin
      plo_q <= 64'(sq_q[31:0]) * 64'(inv_q);
    end
    if (cmd_i.gidx) begin
      idx_q <= idx_d;
    end
    if (cmd_i.grom) begin
      romv_q <= rom[idx_q];
    end
  end

  logic [39:0] gprod;
  logic [31:0] add_val;
  logic [32:0] acc_sum;
  logic [31:0] acc_q;
  logic        accsat_q;

  assign gprod = 40'(a_w) * 40'(romv_q);

  always_comb begin
    case (cmd_i.acc_sel)
      ACC_AMP:   add_val = 32'(a_w);
      ACC_QUOT:  add_val = 32'(qsh_q);
      ACC_GAUSS: add_val = 32'(gprod[39:16]);
      default:   add_val = '0;
    endcase
  end

  assign acc_sum = {1'b0, acc_q} + {1'b0, add_val};

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      t_q      <= time_now_i;
      acc_q    <= bg_q;
      accsat_q <= 1'b0;
      lim_q    <= (int'(active_q) > MaxEvents) ? CW'(MaxEvents) : CW'(active_q);
    end else if (cmd_i.acc_sel != ACC_NONE) begin
      if (acc_sum[32]) begin
        acc_q    <= '1;
        accsat_q <= 1'b1;
      end else begin
        acc_q <= acc_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (cmd_i.init) begin
      i_q <= '0;
    end else if (cmd_i.next) begin
      i_q <= i_q + CW'(1);
    end
  end

  logic        out_valid_q;
  logic [31:0] heat_q;
  logic        sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      heat_q <= acc_q;
      sat_q  <= accsat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign heat_o      = heat_q;
  assign saturated_o = sat_q;

  assign status_o.last       = i_q == lim_q;
  assign status_o.in_range   = (t_q >= s_w) && (t_q <= e_w);
  assign status_o.zero_width = width_w == '0;
  assign status_o.div_done   = dcnt_q == 5'd1;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign status_o.mode       = shape_q;

endmodule
`default_nettype wire

// ===== src/pths_ctrl.sv =====
// Controller state machine that sequences loads and evaluations through the datapath.
`default_nettype none
module pths_ctrl import pths_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         command_i,
  output logic              in_ready_o,
  input  wire pths_status_t status_i,
  output pths_cmd_t         cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_FETCH  = 15'b000000000000010,
    S_CHECK  = 15'b000000000000100,
    S_TMUL   = 15'b000000000001000,
    S_TLOAD  = 15'b000000000010000,
    S_TDIV   = 15'b000000000100000,
    S_TACC   = 15'b000000001000000,
    S_GSQ    = 15'b000000010000000,
    S_GHI    = 15'b000000100000000,
    S_GLO    = 15'b000001000000000,
    S_GIDX   = 15'b000010000000000,
    S_GROM   = 15'b000100000000000,
    S_GACC   = 15'b001000000000000,
    S_FINISH = 15'b010000000000000,
    S_SPARE  = 15'b100000000000000
  } pths_state_e;

  pths_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_EVAL) begin
            cmd_o.init = 1'b1;
            state_d    = S_FETCH;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (status_i.last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_FETCH;
        if (!status_i.in_range) begin
          cmd_o.next = 1'b1;
        end else begin
          case (status_i.mode)
            MODE_SQUARE: begin
              cmd_o.acc_sel = ACC_AMP;
              cmd_o.next    = 1'b1;
            end
            MODE_TRI: begin
              if (status_i.zero_width) begin
                cmd_o.next = 1'b1;
              end else begin
                state_d = S_TMUL;
              end
            end
            MODE_GAUSS: state_d = S_GSQ;
            default: cmd_o.next = 1'b1;
          endcase
        end
      end
      S_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d    = S_TLOAD;
      end
      S_TLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_TDIV;
      end
      S_TDIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_TACC;
        end
      end
      S_TACC: begin
        cmd_o.acc_sel = ACC_QUOT;
        cmd_o.next    = 1'b1;
        state_d       = S_FETCH;
      end
      S_GSQ: begin
        cmd_o.gsq = 1'b1;
        state_d   = S_GHI;
      end
      S_GHI: begin
        cmd_o.ghi = 1'b1;
        state_d   = S_GLO;
      end
      S_GLO: begin
        cmd_o.glo = 1'b1;
        state_d   = S_GIDX;
      end
      S_GIDX: begin
        cmd_o.gidx = 1'b1;
        state_d    = S_GROM;
      end
      S_GROM: begin
        cmd_o.grom = 1'b1;
        state_d    = S_GACC;
      end
      S_GACC: begin
        cmd_o.acc_sel = ACC_GAUSS;
        cmd_o.next    = 1'b1;
        state_d       = S_FETCH;
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
